// ===== rtl/lmst_pkg.sv =====
// Shared widths, op codes, control bundles and saturation helper for the LMS trainer.
package lmst_pkg;

    localparam int X_WIDTH    = 16;
    localparam int W_WIDTH    = 32;
    localparam int LE_WIDTH   = 34;
    localparam int MUL_WIDTH  = LE_WIDTH + X_WIDTH;
    localparam int PROD_WIDTH = W_WIDTH + X_WIDTH;
    localparam int NUM_IN     = 4;

    localparam logic [1:0] OP_TRAIN = 2'd0;
    localparam logic [1:0] OP_EVAL  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [15:0] LR_RESET = 16'd655;

    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
        logic clr;
    } t_lane_ctrl;

    typedef struct packed {
        logic sum_en;
        logic le_en;
    } t_merge_ctrl;

    // Clamp a 35-bit sum into the signed 32-bit weight range.
    function automatic logic signed [W_WIDTH-1:0] sat_weight(
        input logic signed [W_WIDTH+2:0] v
    );
        logic signed [W_WIDTH-1:0] r;
        if (v[W_WIDTH+2:W_WIDTH-1] == '0 || v[W_WIDTH+2:W_WIDTH-1] == '1) begin
            r = v[W_WIDTH-1:0];
        end else if (v[W_WIDTH+2]) begin
            r = {1'b1, {(W_WIDTH-1){1'b0}}};
        end else begin
            r = {1'b0, {(W_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== rtl/lmst_lane.sv =====
// One feature lane: weight register, feature register and a shared multiplier for
// the dot product term and the weight update.
module lmst_lane
    import lmst_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_lane_ctrl                   i_ctrl,
    input  logic signed [X_WIDTH-1:0]    i_x,
    input  logic signed [LE_WIDTH-1:0]   i_le,
    output logic signed [PROD_WIDTH-1:0] o_prod
);

    logic signed [W_WIDTH-1:0]    r_w;
    logic signed [W_WIDTH-1:0]    n_w;
    logic signed [X_WIDTH-1:0]    r_x;
    logic signed [PROD_WIDTH-1:0] r_prod;

    logic signed [LE_WIDTH-1:0]   mul_a;
    logic signed [MUL_WIDTH-1:0]  mul_p;
    logic signed [LE_WIDTH-1:0]   step;
    logic signed [W_WIDTH+2:0]    w_sum;

    // During the update the multiplier forms le*x, otherwise w*x.
    assign mul_a = i_ctrl.upd ? i_le : {{(LE_WIDTH-W_WIDTH){r_w[W_WIDTH-1]}}, r_w};
    assign mul_p = mul_a * r_x;
    assign step  = mul_p[MUL_WIDTH-1:16];
    assign w_sum = {{3{r_w[W_WIDTH-1]}}, r_w}
                 + {{(W_WIDTH+3-LE_WIDTH){step[LE_WIDTH-1]}}, step};

    always_comb begin
        n_w = r_w;
        if (i_ctrl.clr) begin
            n_w = '0;
        end else if (i_ctrl.upd) begin
            n_w = sat_weight(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
        end else begin
            r_w <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_x;
        end
        if (i_ctrl.mul) begin
            r_prod <= mul_p[PROD_WIDTH-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/lmst_merge.sv =====
// Merging stage: sums the lane products with the bias, saturates the prediction,
// checks the integer match and forms the scaled error for the update.
module lmst_merge
    import lmst_pkg::*;
#(
    parameter int FEATURES = 4
)
(
    input  logic                         i_clk,
    input  t_merge_ctrl                  i_ctrl,
    input  logic signed [PROD_WIDTH-1:0] i_prod [FEATURES],
    input  logic signed [W_WIDTH-1:0]    i_bias,
    input  logic signed [X_WIDTH-1:0]    i_target,
    input  logic        [15:0]           i_lr,
    output logic signed [X_WIDTH-1:0]    o_pred,
    output logic                         o_match,
    output logic signed [LE_WIDTH-1:0]   o_le
);

    localparam int ACC_W = PROD_WIDTH + $clog2(FEATURES + 1);
    localparam logic signed [ACC_W-1:0] P_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] P_MIN = ACC_W'(-32768);

    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [ACC_W-1:0]    acc_sh;
    logic signed [X_WIDTH-1:0]  pred;
    logic signed [X_WIDTH:0]    p17;
    logic signed [X_WIDTH:0]    mag;
    logic signed [X_WIDTH:0]    trunc;
    logic signed [X_WIDTH:0]    err;
    logic signed [LE_WIDTH-1:0] r_le;

    always_comb begin
        acc_sum = {{(ACC_W-W_WIDTH-8){i_bias[W_WIDTH-1]}}, i_bias, 8'b0};
        for (int j = 0; j < FEATURES; j++) begin
            acc_sum = acc_sum
                    + {{(ACC_W-PROD_WIDTH){i_prod[j][PROD_WIDTH-1]}}, i_prod[j]};
        end
    end

    always_comb begin
        acc_sh = r_acc >>> 16;
        if (acc_sh > P_MAX) begin
            pred = 16'sh7fff;
        end else if (acc_sh < P_MIN) begin
            pred = 16'sh8000;
        end else begin
            pred = acc_sh[X_WIDTH-1:0];
        end
        // Truncation toward zero drops the fraction of the magnitude.
        p17 = {pred[X_WIDTH-1], pred};
        mag = p17[X_WIDTH] ? -p17 : p17;
        mag = {mag[X_WIDTH:8], 8'b0};
        trunc = p17[X_WIDTH] ? -mag : mag;
        err = {i_target[X_WIDTH-1], i_target} - p17;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum_en) begin
            r_acc <= acc_sum;
        end
        if (i_ctrl.le_en) begin
            r_le <= $signed({1'b0, i_lr}) * err;
        end
    end

    assign o_pred  = pred;
    assign o_match = (trunc == {i_target[X_WIDTH-1], i_target});
    assign o_le    = r_le;

endmodule

// ===== rtl/lms_linear_regression_trainer.sv =====
// Streaming LMS trainer for a linear model with a bias and FEATURES weights.
// Each accepted word runs through four steps: the lanes multiply weights by
// features, the merging stage adds the products and the bias, the prediction is
// saturated and sent to the output register while the scaled error is formed,
// and the lanes then train or clear weights. A new word is taken in the update
// step, so a word is not accepted before the previous one reaches its update;
// this is set by the weight dependence between consecutive samples. A result
// that waits at the output holds the block in the prediction step until it is
// taken. The learning rate may be written only while the block is idle.
module lms_linear_regression_trainer
    import lmst_pkg::*;
#(
    parameter int FEATURES = 4
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_lr_we,
    input  logic [15:0]               i_lr_wdata,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_op,
    input  logic signed [X_WIDTH-1:0] i_feature_one,
    input  logic signed [X_WIDTH-1:0] i_feature_two,
    input  logic signed [X_WIDTH-1:0] i_feature_three,
    input  logic signed [X_WIDTH-1:0] i_feature_four,
    input  logic signed [X_WIDTH-1:0] i_target,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [X_WIDTH-1:0] o_prediction,
    output logic                      o_matches_res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SUM  = 5'b00100,
        S_PRED = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]                 r_op;
    logic signed [X_WIDTH-1:0]  r_target;
    logic [15:0]                r_lr;
    logic signed [W_WIDTH-1:0]  r_w0;
    logic signed [W_WIDTH-1:0]  n_w0;
    logic                       r_ovalid;
    logic                       n_ovalid;
    logic signed [X_WIDTH-1:0]  r_pred;
    logic                       r_match;

    logic                       accept;
    logic                       out_free;
    logic                       out_load;
    t_lane_ctrl                 lane_ctrl;
    t_merge_ctrl                merge_ctrl;

    logic signed [X_WIDTH-1:0]    feat [NUM_IN];
    logic signed [PROD_WIDTH-1:0] prod [FEATURES];
    logic signed [X_WIDTH-1:0]    m_pred;
    logic                         m_match;
    logic signed [LE_WIDTH-1:0]   le;
    logic signed [LE_WIDTH-9:0]   step0;
    logic signed [W_WIDTH+2:0]    w0_sum;

    assign feat[0] = i_feature_one;
    assign feat[1] = i_feature_two;
    assign feat[2] = i_feature_three;
    assign feat[3] = i_feature_four;

    assign o_stall  = !i_rst_n || !(r_state == S_IDLE || r_state == S_UPD);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign out_load = (r_state == S_PRED) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_PRED;
            S_PRED:  if (out_free) n_state = S_UPD;
            S_UPD:   n_state = accept ? S_MUL : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        lane_ctrl.load    = accept;
        lane_ctrl.mul     = (r_state == S_MUL);
        lane_ctrl.upd     = (r_state == S_UPD) && (r_op == OP_TRAIN);
        lane_ctrl.clr     = (r_state == S_UPD) && (r_op == OP_CLEAR);
        merge_ctrl.sum_en = (r_state == S_SUM);
        merge_ctrl.le_en  = (r_state == S_PRED);
    end

    genvar j;
    generate
        for (j = 0; j < FEATURES; j++) begin : g_lane
            logic signed [X_WIDTH-1:0] lane_x;
            if (j < NUM_IN) begin : g_x
                assign lane_x = feat[j];
            end else begin : g_zero
                assign lane_x = '0;
            end
            lmst_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (lane_ctrl),
                .i_x     (lane_x),
                .i_le    (le),
                .o_prod  (prod[j])
            );
        end
    endgenerate

    lmst_merge #(
        .FEATURES (FEATURES)
    ) u_merge (
        .i_clk    (i_clk),
        .i_ctrl   (merge_ctrl),
        .i_prod   (prod),
        .i_bias   (r_w0),
        .i_target (r_target),
        .i_lr     (r_lr),
        .o_pred   (m_pred),
        .o_match  (m_match),
        .o_le     (le)
    );

    // The bias sees the error scaled by the rate, floored to Q16.16.
    assign step0  = le[LE_WIDTH-1:8];
    assign w0_sum = {{3{r_w0[W_WIDTH-1]}}, r_w0}
                  + {{(W_WIDTH+3-(LE_WIDTH-8)){step0[LE_WIDTH-9]}}, step0};

    always_comb begin
        n_w0 = r_w0;
        if (lane_ctrl.clr) begin
            n_w0 = '0;
        end else if (lane_ctrl.upd) begin
            n_w0 = sat_weight(w0_sum);
        end
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lr     <= LR_RESET;
            r_w0     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_w0     <= n_w0;
            r_ovalid <= n_ovalid;
            if (i_lr_we) begin
                r_lr <= i_lr_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_op;
            r_target <= i_target;
        end
        if (out_load) begin
            if (r_op == OP_CLEAR) begin
                r_pred  <= '0;
                r_match <= 1'b0;
            end else begin
                r_pred  <= m_pred;
                r_match <= m_match;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_prediction  = r_pred;
    assign o_matches_res = r_match;

endmodule

// ===== rtl/lmst_checker.sv =====
// Port-level checks for the LMS trainer and the bind that attaches them.
module lmst_port_checker
    import lmst_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic [1:0]                i_op,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic signed [X_WIDTH-1:0] o_prediction,
    input logic                      o_matches_res
);

    logic in_acc;
    assign in_acc = i_valid && !o_stall;

    // Reset leaves no word at the output, and the input opens once reset is released.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && (!o_stall || !i_rst_n))
        else $error("state after reset is wrong");

    // After a word is taken, the input stays stalled through the multiply, sum and prediction steps.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##1 o_stall ##1 o_stall ##1 o_stall)
        else $error("word accepted while datapath busy");

    // A clear word reports zero prediction and no match.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_acc && i_op == OP_CLEAR, 4) && $past(i_rst_n, 4)
        && $past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1)
        && $past(!o_valid || !i_stall, 1)
        |-> o_valid && o_prediction == '0 && !o_matches_res)
        else $error("clear result is wrong");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_prediction)
        && $stable(o_matches_res))
        else $error("stalled result changed");

endmodule

bind lms_linear_regression_trainer lmst_port_checker u_lmst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_op          (i_op),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_prediction  (o_prediction),
    .o_matches_res (o_matches_res)
);

// ===== dv/lmst_checker.sv =====
// Checker for the LMS trainer: watches both channels, predicts every result and compares it.
module lmst_checker
    import lmst_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_lr_we,
    input  logic [15:0]               i_lr_wdata,
    input  logic                      i_smp_valid,
    input  logic                      i_smp_stall,
    input  logic [1:0]                i_op,
    input  logic signed [X_WIDTH-1:0] i_feature_one,
    input  logic signed [X_WIDTH-1:0] i_feature_two,
    input  logic signed [X_WIDTH-1:0] i_feature_three,
    input  logic signed [X_WIDTH-1:0] i_feature_four,
    input  logic signed [X_WIDTH-1:0] i_target,
    input  logic                      i_res_valid,
    input  logic                      i_res_stall,
    input  logic signed [X_WIDTH-1:0] i_prediction,
    input  logic                      i_matches_res,
    output int                        o_pending,
    output int                        o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint W_TOP    = 64'sd2147483647;
    localparam longint W_BOTTOM = -W_TOP - 1;

    typedef struct packed {
        logic signed [X_WIDTH-1:0] prediction;
        logic                      hit;
    } t_lms_result;

    logic [15:0]               learn_rate = LR_RESET;
    logic signed [W_WIDTH-1:0] weight_regs [NUM_IN+1];
    t_lms_result               awaited_results [$];
    int                        mismatches = 0;

    function automatic logic signed [W_WIDTH-1:0] clamp_weight(input longint v);
        longint c;
        c = v;
        if (c > W_TOP) begin
            c = W_TOP;
        end else if (c < W_BOTTOM) begin
            c = W_BOTTOM;
        end
        return W_WIDTH'(c);
    endfunction

    // Predicts from current weights, then trains them on a train word; a clear zeroes them.
    function automatic t_lms_result lms_step(
        input logic [1:0]                op,
        input logic signed [X_WIDTH-1:0] f1,
        input logic signed [X_WIDTH-1:0] f2,
        input logic signed [X_WIDTH-1:0] f3,
        input logic signed [X_WIDTH-1:0] f4,
        input logic signed [X_WIDTH-1:0] tgt
    );
        t_lms_result r;
        longint      x [NUM_IN+1];
        longint      acc;
        longint      pred;
        longint      whole;
        longint      le;
        r    = '0;
        x[0] = 0;
        x[1] = f1;
        x[2] = f2;
        x[3] = f3;
        x[4] = f4;
        if (op == OP_CLEAR) begin
            foreach (weight_regs[j]) weight_regs[j] = '0;
        end else begin
            acc = longint'(weight_regs[0]) * 256;
            for (int j = 1; j <= NUM_IN; j++) begin
                acc += longint'(weight_regs[j]) * x[j];
            end
            pred = acc >>> 16;
            if (pred > 32767) begin
                pred = 32767;
            end else if (pred < -32768) begin
                pred = -32768;
            end
            // Cutting the fraction toward zero works on the magnitude.
            whole = (pred >= 0) ? (pred & ~longint'(255)) : -((-pred) & ~longint'(255));
            r.prediction = X_WIDTH'(pred);
            r.hit        = (whole == longint'(tgt));
            if (op == OP_TRAIN) begin
                le = longint'(learn_rate) * (longint'(tgt) - pred);
                weight_regs[0] = clamp_weight(longint'(weight_regs[0]) + (le >>> 8));
                for (int j = 1; j <= NUM_IN; j++) begin
                    weight_regs[j] = clamp_weight(longint'(weight_regs[j]) +
                                                  ((le * x[j]) >>> 16));
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lms_result want;
        t_lms_result fresh;
        if (!i_rst_n) begin
            learn_rate = LR_RESET;
            foreach (weight_regs[j]) weight_regs[j] = '0;
            awaited_results.delete();
        end else begin
            if (i_lr_we) begin
                learn_rate = i_lr_wdata;
            end
            // The result side is checked first so that a word taken at this edge
            // cannot stand in for a missing older one.
            if (i_res_valid && !i_res_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("prediction: expected no word, actual %0d", i_prediction);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_prediction !== want.prediction) begin
                        $error("prediction: expected %0d, actual %0d",
                               want.prediction, i_prediction);
                        mismatches++;
                    end
                    if (i_matches_res !== want.hit) begin
                        $error("matches_res: expected %0d, actual %0d",
                               want.hit, i_matches_res);
                        mismatches++;
                    end
                end
            end
            if (i_smp_valid && !i_smp_stall) begin
                fresh = lms_step(i_op, i_feature_one, i_feature_two,
                                 i_feature_three, i_feature_four, i_target);
                awaited_results = {awaited_results, fresh};
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the LMS trainer: clock, reset, stimulus, idling and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lmst_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 16;
    localparam int         PHASES         = 11;
    localparam int         PHASE_ITEMS    = 150;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        lr_we     = 1'b0;
    logic [15:0] lr_wdata  = '0;
    logic        smp_valid = 1'b0;
    logic        smp_stall;
    logic [1:0]  smp_op    = OP_TRAIN;
    logic signed [X_WIDTH-1:0] smp_feature_one   = '0;
    logic signed [X_WIDTH-1:0] smp_feature_two   = '0;
    logic signed [X_WIDTH-1:0] smp_feature_three = '0;
    logic signed [X_WIDTH-1:0] smp_feature_four  = '0;
    logic signed [X_WIDTH-1:0] smp_target        = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic signed [X_WIDTH-1:0] res_prediction;
    logic        res_matches;

    int   pending;
    int   fail_count;
    logic idle_on      = 1'b1;
    int   rx_hold      = 0;
    int   quiet_cycles = 0;
    // Coefficients of the linear rule that well-formed targets follow, Q8.8.
    int   hidden_coef [NUM_IN+1];

    lms_linear_regression_trainer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_lr_we         (lr_we),
        .i_lr_wdata      (lr_wdata),
        .i_valid         (smp_valid),
        .o_stall         (smp_stall),
        .i_op            (smp_op),
        .i_feature_one   (smp_feature_one),
        .i_feature_two   (smp_feature_two),
        .i_feature_three (smp_feature_three),
        .i_feature_four  (smp_feature_four),
        .i_target        (smp_target),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_prediction    (res_prediction),
        .o_matches_res   (res_matches)
    );

    lmst_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_lr_we         (lr_we),
        .i_lr_wdata      (lr_wdata),
        .i_smp_valid     (smp_valid),
        .i_smp_stall     (smp_stall),
        .i_op            (smp_op),
        .i_feature_one   (smp_feature_one),
        .i_feature_two   (smp_feature_two),
        .i_feature_three (smp_feature_three),
        .i_feature_four  (smp_feature_four),
        .i_target        (smp_target),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_prediction    (res_prediction),
        .i_matches_res   (res_matches),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    always #2 clk = ~clk;

    // With idling on, the result side stalls in bursts that never run back to back.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            rx_hold = 0;
        end else if (rx_hold > 0) begin
            res_stall <= 1'b1;
            rx_hold = rx_hold - 1;
        end else if (!res_stall && idle_on && $urandom_range(0, 5) == 0) begin
            res_stall <= 1'b1;
            rx_hold = $urandom_range(0, 12);
        end else begin
            res_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((smp_valid && !smp_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Valid stays high from one word to the next unless a gap is inserted.
    task automatic send_word(
        input logic [1:0]  op,
        input logic [15:0] f1,
        input logic [15:0] f2,
        input logic [15:0] f3,
        input logic [15:0] f4,
        input logic [15:0] tgt
    );
        if (idle_on && $urandom_range(0, 4) == 0) begin
            smp_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        smp_valid         <= 1'b1;
        smp_op            <= op;
        smp_feature_one   <= f1;
        smp_feature_two   <= f2;
        smp_feature_three <= f3;
        smp_feature_four  <= f4;
        smp_target        <= tgt;
        do @(posedge clk); while (smp_stall);
    endtask

    task automatic settle();
        smp_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_rate(input logic [15:0] value);
        settle();
        lr_we    <= 1'b1;
        lr_wdata <= value;
        @(posedge clk);
        lr_we    <= 1'b0;
    endtask

    function automatic logic [15:0] rand_feature(input bit narrow);
        logic [15:0] v;
        if (narrow) begin
            v = 16'($urandom_range(0, 1536)) - 16'd768;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    case ($urandom_range(0, 3))
                        0:       v = 16'h8000;
                        1:       v = 16'h7FFF;
                        2:       v = 16'h0000;
                        default: v = 16'hFFFF;
                    endcase
                end
                default: v = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    function automatic logic [15:0] fit_target(
        input logic signed [15:0] f1,
        input logic signed [15:0] f2,
        input logic signed [15:0] f3,
        input logic signed [15:0] f4
    );
        longint acc;
        acc = longint'(hidden_coef[0]) * 256 + longint'(hidden_coef[1]) * f1 +
              longint'(hidden_coef[2]) * f2 + longint'(hidden_coef[3]) * f3 +
              longint'(hidden_coef[4]) * f4;
        acc = acc >>> 8;
        if (acc > 32767) begin
            acc = 32767;
        end else if (acc < -32768) begin
            acc = -32768;
        end
        // Whole-number targets give the match flag a chance to be set.
        if ($urandom_range(0, 1) == 0) begin
            acc = acc & ~longint'(255);
        end
        return 16'(acc);
    endfunction

    task automatic random_word();
        int          pick;
        bit          tidy;
        logic [1:0]  op;
        logic [15:0] f [4];
        logic [15:0] tgt;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            op = OP_CLEAR;
        end else if (pick < 6) begin
            op = OP_UNUSED;
        end else if (pick < 28) begin
            op = OP_EVAL;
        end else begin
            op = OP_TRAIN;
        end
        tidy = ($urandom_range(0, 3) != 0);
        foreach (f[j]) f[j] = rand_feature(tidy);
        tgt = tidy ? fit_target(f[0], f[1], f[2], f[3]) : rand_feature(1'b0);
        send_word(op, f[0], f[1], f[2], f[3], tgt);
    endtask

    initial begin
        logic [15:0] rate;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset learning rate: zero weights, extremes, clear.
        send_word(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_EVAL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_word(OP_UNUSED, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_word(OP_TRAIN, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100);
        send_word(OP_TRAIN, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_word(OP_TRAIN, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_word(OP_EVAL, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0000);
        send_word(OP_CLEAR, 16'hFFFF, 16'h1234, 16'h8000, 16'h7FFF, 16'h5555);
        send_word(OP_EVAL, 16'h0100, 16'hFF00, 16'h0080, 16'hFF80, 16'h0000);

        // Full-scale rate drives the weights and the prediction into saturation.
        write_rate(16'hFFFF);
        repeat (4) send_word(OP_TRAIN, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_word(OP_EVAL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7F00);
        send_word(OP_EVAL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        repeat (2) send_word(OP_TRAIN, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        send_word(OP_EVAL, 16'hFF00, 16'h0080, 16'hFFFF, 16'h0001, 16'hFF00);

        // A zero rate must leave the weights alone.
        write_rate(16'h0000);
        send_word(OP_TRAIN, 16'h1234, 16'hABCD, 16'h0F0F, 16'hF0F0, 16'h7FFF);
        send_word(OP_EVAL, 16'h1234, 16'hABCD, 16'h0F0F, 16'hF0F0, 16'h7FFF);
        send_word(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_UNUSED, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0000);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       rate = LR_RESET;
                1:       rate = 16'hFFFF;
                2:       rate = 16'h0000;
                default: rate = phase[0] ? 16'($urandom_range(1, 65535))
                                         : 16'($urandom_range(64, 4096));
            endcase
            write_rate(rate);
            idle_on <= (phase == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            foreach (hidden_coef[j]) hidden_coef[j] = int'($urandom_range(0, 1024)) - 512;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_word();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lmst_pkg.sv
rtl/lmst_lane.sv
rtl/lmst_merge.sv
rtl/lms_linear_regression_trainer.sv
rtl/lmst_checker.sv
dv/lmst_checker.sv
dv/tb_top.sv
